// File: src/dksk_pkg.sv
// Shared constants and types for the keep-strongest-by-key scan deduplicator.
// No dependencies; every other file in src imports this package.
`default_nettype none

package dksk_pkg;

	localparam int MAX_ENTRIES = 32;
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	localparam int WORD_W = 64;
	localparam int NAME_BYTES = 32;
	localparam int NAME_W = NAME_BYTES * 8;
	localparam int LVL_W = 8;

	localparam int IN_DATA_W = 264;
	localparam int OUT_DATA_W = 280;

	typedef logic [3:0][WORD_W-1:0] name_t;

	// one classified job handed from the front to the back
	typedef struct packed {
		name_t             name;
		logic [LVL_W-1:0]  strength;
		logic              rec;
		logic              last;
	} job_t;

	typedef struct packed {
		name_t             name;
		logic [LVL_W-1:0]  lvl;
	} entry_t;

endpackage

`default_nettype wire

// File: src/dksk_front.sv
// Input stage: accepts stream items, canonicalizes the name and classifies the item.
// Depends on dksk_pkg.
`default_nettype none

module dksk_front import dksk_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [IN_DATA_W-1:0] in_data,
	input  wire logic                 in_user,
	input  wire logic                 in_last,
	output logic                      job_valid,
	input  wire logic                 job_ready,
	output job_t                      job
);

	logic [NAME_W-1:0]     raw_name;
	logic [NAME_W-1:0]     canon;
	logic [NAME_BYTES-1:0] nz;
	logic                  rec;
	logic                  valid_s1;
	job_t                  job_s1;

	assign raw_name = in_data[NAME_W-1:0];

	// zero every byte after the first zero byte
	always_comb begin
		logic [NAME_BYTES-1:0] low;
		canon = '0;
		for (int k = 0; k < NAME_BYTES; k++) begin
			nz[k] = |raw_name[8*k +: 8];
		end
		for (int k = 0; k < NAME_BYTES; k++) begin
			low = (NAME_BYTES'(1) << k) - NAME_BYTES'(1);
			canon[8*k +: 8] = ((nz & low) == low) ? raw_name[8*k +: 8] : 8'h00;
		end
	end

	assign rec = in_user & nz[0];
	assign in_ready = !valid_s1 || job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			// drop items that carry neither a record nor an end mark
			valid_s1 <= in_valid && (rec || in_last);
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			job_s1.name     <= canon;
			job_s1.strength <= in_data[NAME_W +: LVL_W];
			job_s1.rec      <= rec;
			job_s1.last     <= in_last;
		end
	end

	assign job_valid = valid_s1;
	assign job = job_s1;

endmodule

`default_nettype wire

// File: src/dksk_queue.sv
// Two-entry job queue between the front and the back.
// Depends on dksk_pkg.
`default_nettype none

module dksk_queue import dksk_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_valid,
	output logic      wr_ready,
	input  job_t      wr_job,
	output logic      rd_valid,
	input  wire logic rd_ready,
	output job_t      rd_job
);

	job_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;
	assign rd_job = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= wr_job;
	end

endmodule

`default_nettype wire

// File: src/dksk_back.sv
// Back end: entry table memory, lookup/insert sequencer and result emitter.
// Depends on dksk_pkg.
`default_nettype none

module dksk_back import dksk_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  job_valid,
	output logic                       job_ready,
	input  job_t                       job,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [OUT_DATA_W-1:0]      out_data,
	output logic                       out_user,
	output logic                       out_last
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMPTY
	} state_t;

	state_t                  state_q;
	job_t                    job_q;
	logic [CNT_W-1:0]        fill_q;
	logic                    dropped_q;
	logic [CNT_W-1:0]        issue_idx_q;
	logic                    cmp_v_q;
	logic [IDX_W-1:0]        cmp_idx_q;
	logic [IDX_W-1:0]        emit_idx_q;
	logic                    out_valid_q;
	logic [OUT_DATA_W-1:0]   out_data_q;
	logic                    out_user_q;
	logic                    out_last_q;

	entry_t                  mem [MAX_ENTRIES];
	entry_t                  rd_q;
	logic [IDX_W-1:0]        ra;
	logic                    we;
	logic [IDX_W-1:0]        wa;
	entry_t                  wd;

	logic                    scan_done;
	logic                    hit;
	logic                    miss;
	logic                    issue;
	logic                    stronger;
	logic                    room;
	logic                    ld_ok;
	logic                    load;
	logic                    final_one;

	assign scan_done = (issue_idx_q == fill_q);
	assign hit = cmp_v_q && (rd_q.name == job_q.name);
	assign miss = scan_done && !hit;
	assign issue = (state_q == ST_SCAN) && !scan_done && !hit;
	assign stronger = $signed(job_q.strength) > $signed(rd_q.lvl);
	assign room = (fill_q < CNT_W'(MAX_ENTRIES));
	assign ld_ok = !out_valid_q || out_ready;
	// a result is loaded into the output register this cycle
	assign load = ((state_q == ST_EMIT_LD) || (state_q == ST_EMPTY)) && ld_ok;
	assign final_one = ((CNT_W'(emit_idx_q) + CNT_W'(1)) == fill_q);
	assign job_ready = (state_q == ST_IDLE);

	always_comb begin
		ra = (state_q == ST_SCAN) ? issue_idx_q[IDX_W-1:0] : emit_idx_q;
		we = 1'b0;
		wa = cmp_idx_q;
		wd.name = job_q.name;
		wd.lvl = job_q.strength;
		if (state_q == ST_SCAN) begin
			if (hit && stronger) begin
				we = 1'b1;
			end else if (miss && room) begin
				we = 1'b1;
				wa = fill_q[IDX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= '0;
			fill_q      <= '0;
			dropped_q   <= 1'b0;
			issue_idx_q <= '0;
			cmp_v_q     <= 1'b0;
			cmp_idx_q   <= '0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_user_q  <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					cmp_v_q     <= 1'b0;
					issue_idx_q <= '0;
					emit_idx_q  <= '0;
					if (job_valid) begin
						job_q <= job;
						if (job.rec) state_q <= ST_SCAN;
						else if (fill_q == '0) state_q <= ST_EMPTY;
						else state_q <= ST_EMIT_RD;
					end
				end
				ST_SCAN: begin
					issue_idx_q <= issue_idx_q + CNT_W'(issue);
					cmp_v_q     <= issue;
					cmp_idx_q   <= issue_idx_q[IDX_W-1:0];
					if (hit || miss) begin
						if (miss) begin
							if (room) fill_q <= fill_q + CNT_W'(1);
							else dropped_q <= 1'b1;
						end
						state_q <= job_q.last ? ST_EMIT_RD : ST_IDLE;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					if (ld_ok) begin
						out_user_q  <= 1'b0;
						out_last_q  <= final_one;
						out_data_q  <= {2'b00, dropped_q, 7'(fill_q), 6'(emit_idx_q),
							rd_q.lvl, rd_q.name};
						if (final_one) begin
							fill_q    <= '0;
							dropped_q <= 1'b0;
							state_q   <= ST_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + IDX_W'(1);
							state_q    <= ST_EMIT_RD;
						end
					end
				end
				ST_EMPTY: begin
					if (ld_ok) begin
						out_user_q  <= 1'b1;
						out_last_q  <= 1'b1;
						out_data_q  <= '0;
						dropped_q   <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
	assign out_user = out_user_q;
	assign out_last = out_last_q;

endmodule

`default_nettype wire

// File: src/dedup_keep_strongest_by_key_core.sv
// Keep-strongest-by-key scan deduplicator, top level; uses dksk_front, dksk_queue, dksk_back.
// A record is compared with the table one entry per cycle up to a hit or the fill, then its
// entry is updated or inserted; an end mark emits the table, each result read and then loaded
// as the output register frees. Jobs queue while a scan holds the table's single read port.
// Reset (arst_n low, asynchronous): clears the queue, table fill count and overflow flag;
// table contents need no clearing.
`default_nettype none

module dedup_keep_strongest_by_key_core import dksk_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input records
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// from bit 0: name_w0, name_w1, name_w2, name_w3, strength
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// bit 0: present
	input  wire logic                  s_tuser,
	// scan_end
	input  wire logic                  s_tlast,
	// results
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// from bit 0: out_w0, out_w1, out_w2, out_w3, best_strength, entry_index,
	// unique_total, overflow, two zero pad bits
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// bit 0: empty_res
	output logic                       m_tuser,
	// final_res
	output logic                       m_tlast
);

	logic f_valid;
	logic f_ready;
	job_t f_job;
	logic q_valid;
	logic q_ready;
	job_t q_job;

	// front: canonicalize the name, drop items with nothing to do
	dksk_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.in_last   (s_tlast),
		.job_valid (f_valid),
		.job_ready (f_ready),
		.job       (f_job)
	);

	// hold jobs while the back end scans the table
	dksk_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_job   (f_job),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_job   (q_job)
	);

	// back: look up, update or insert, and emit the table on an end mark
	dksk_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job_ready (q_ready),
		.job       (q_job),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

`default_nettype wire

// File: tb/sv/dksk_scan_checker.sv
// Checker for the keep-strongest-by-key scan deduplicator: watches both stream channels,
// predicts the result run of every scan and compares each result transfer in order.
// Depends on dksk_pkg for the name type and the channel widths.
`default_nettype none

module dksk_scan_checker import dksk_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  s_tuser,
	input  wire logic                  s_tlast,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata,
	input  wire logic                  m_tuser,
	input  wire logic                  m_tlast,
	output int                         fail_count,
	output int                         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic             empty;
		name_t            name;
		logic [LVL_W-1:0] lvl;
		logic [5:0]       idx;
		logic [6:0]       total;
		logic             ovf;
		logic             fin;
	} scan_res_t;

	// predicted scan table
	name_t            seen_name [MAX_ENTRIES];
	logic [LVL_W-1:0] seen_lvl [MAX_ENTRIES];
	int               seen_fill = 0;
	logic             lost_name = 1'b0;

	scan_res_t        due_q [$];
	int               mismatches = 0;

	// clear every byte past the first zero byte
	function automatic name_t trim_name(name_t raw);
		logic [NAME_W-1:0] flat;
		bit ended;
		flat = raw;
		ended = 1'b0;
		for (int k = 0; k < NAME_BYTES; k++) begin
			if (ended)
				flat[k*8 +: 8] = 8'h00;
			else if (flat[k*8 +: 8] == 8'h00)
				ended = 1'b1;
		end
		return flat;
	endfunction

	// fold one input transfer into the table; an end mark queues the whole run
	function automatic void absorb_scan_item(logic present, name_t raw, logic [LVL_W-1:0] lvl,
			logic last);
		name_t nm;
		int hit;
		scan_res_t r;
		nm = trim_name(raw);
		hit = -1;
		if (present && nm[0][7:0] != 8'h00) begin
			for (int j = 0; j < seen_fill; j++)
				if (hit < 0 && seen_name[j] == nm)
					hit = j;
			if (hit >= 0) begin
				if ($signed(lvl) > $signed(seen_lvl[hit]))
					seen_lvl[hit] = lvl;
			end else if (seen_fill < MAX_ENTRIES) begin
				seen_name[seen_fill] = nm;
				seen_lvl[seen_fill] = lvl;
				seen_fill++;
			end else begin
				lost_name = 1'b1;
			end
		end
		if (last) begin
			if (seen_fill == 0) begin
				r = '0;
				r.empty = 1'b1;
				r.fin = 1'b1;
				due_q.push_back(r);
			end
			for (int j = 0; j < seen_fill; j++) begin
				r = '0;
				r.name = seen_name[j];
				r.lvl = seen_lvl[j];
				r.idx = 6'(j);
				r.total = 7'(seen_fill);
				r.ovf = lost_name;
				r.fin = (j == seen_fill - 1);
				due_q.push_back(r);
			end
			seen_fill = 0;
			lost_name = 1'b0;
		end
	endfunction

	function automatic string show(scan_res_t r);
		return $sformatf("empty=%b name=%h lvl=%0d idx=%0d total=%0d ovf=%b fin=%b",
			r.empty, r.name, $signed(r.lvl), r.idx, r.total, r.ovf, r.fin);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		scan_res_t got;
		scan_res_t want;
		if (!arst_n) begin
			seen_fill = 0;
			lost_name = 1'b0;
			due_q.delete();
			mismatches = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (s_tvalid && s_tready)
				absorb_scan_item(s_tuser, s_tdata[NAME_W-1:0], s_tdata[NAME_W +: LVL_W], s_tlast);
			if (m_tvalid && m_tready) begin
				got.empty = m_tuser;
				got.name  = m_tdata[NAME_W-1:0];
				got.lvl   = m_tdata[NAME_W +: LVL_W];
				got.idx   = m_tdata[NAME_W+LVL_W +: 6];
				got.total = m_tdata[NAME_W+LVL_W+6 +: 7];
				got.ovf   = m_tdata[NAME_W+LVL_W+13];
				got.fin   = m_tlast;
				if (due_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with none outstanding: %s", $time, show(got));
				end else begin
					want = due_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: result mismatch", $time);
							$display("  expected %s", show(want));
							$display("  actual   %s", show(got));
						end
					end
				end
			end
			pending <= due_q.size();
			fail_count <= mismatches;
		end
	end

endmodule

`default_nettype wire

// File: tb/sv/tb_dedup_keep_strongest_by_key_core.sv
// Testbench top for dedup_keep_strongest_by_key_core: drives scan records with random idling
// on both channels and gives the verdict; dksk_scan_checker does prediction and comparison.
// Depends on dksk_pkg, the core and dksk_scan_checker.
`default_nettype none

module tb_dedup_keep_strongest_by_key_core;
	timeunit 1ns;
	timeprecision 1ps;
	import dksk_pkg::*;

	// generous bound: a few hundred records, each scanned against the table, plus stalled result runs
	localparam int unsigned CYCLE_LIMIT = 500_000;
	// quiet cycles after the last expected result, so that any extra result is still seen
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_ITEMS = 210;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// from bit 0: name_w0, name_w1, name_w2, name_w3, strength
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	// present
	logic                  s_tuser = 1'b0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// from bit 0: out_w0..out_w3, best_strength, entry_index, unique_total, overflow, pad
	logic [OUT_DATA_W-1:0] m_tdata;
	// empty_res
	logic                  m_tuser;
	logic                  m_tlast;

	int                    fail_count;
	int                    pending;
	int                    send_idle_pct = 19;
	int                    recv_idle_pct = 63;
	int                    items_sent = 0;
	int unsigned           cycle_count = 0;

	dedup_keep_strongest_by_key_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	dksk_scan_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver: stall at random, rate set per phase
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// hard stop if the run hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Offer one item, with an optional random gap first, and hold it until the transfer.
	// tvalid stays high on return so back-to-back items never drop it within a step.
	task automatic push_item(input logic present, input name_t nm, input logic [LVL_W-1:0] lvl,
			input logic last);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {lvl, nm};
		s_tuser  <= present;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		// ignored items do not advance the stimulus budget
		if (last || (present && nm[0][7:0] != 8'h00))
			items_sent++;
	endtask

	// name of len nonzero bytes, zero filled after them
	function automatic name_t make_name(int len);
		logic [NAME_W-1:0] f;
		f = '0;
		for (int k = 0; k < len; k++)
			f[k*8 +: 8] = 8'($urandom_range(255, 1));
		return f;
	endfunction

	// fill the bytes past the terminator with junk half of the time
	function automatic name_t dress(name_t canon, int len);
		logic [NAME_W-1:0] f;
		f = canon;
		if ($urandom_range(1) == 1)
			for (int k = len + 1; k < NAME_BYTES; k++)
				f[k*8 +: 8] = 8'($urandom);
		return f;
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return 0;
		if (r < 25)
			return NAME_BYTES;
		if (r < 40)
			return $urandom_range(NAME_BYTES - 1, 1);
		return $urandom_range(8, 1);
	endfunction

	function automatic logic [LVL_W-1:0] rand_lvl();
		case ($urandom_range(9))
			0: return 8'h80;
			1: return 8'h7f;
			default: return 8'($urandom);
		endcase
	endfunction

	initial begin : stimulus
		name_t nm_a;
		name_t nm_a_junk;
		name_t nm_a_junk2;
		name_t nm_full;
		name_t nm_term31;
		name_t nm_hi;
		name_t nm_void_junk;
		name_t pool_name [40];
		int    pool_len [40];
		int    n_pool;
		int    n_items;
		int    pick;
		int    start;
		int    scan_no;
		logic  last;
		logic  present;

		nm_a = '0;
		nm_a[0] = 64'h61;
		// same name, junk after the terminator in every word
		nm_a_junk = '1;
		nm_a_junk[0] = 64'hDEAD_BEEF_1234_0061;
		nm_a_junk2 = '0;
		nm_a_junk2[0] = 64'h0000_0000_0000_0061;
		nm_a_junk2[2] = 64'h8000_0000_0000_0001;
		nm_full = '1;
		nm_term31 = '1;
		nm_term31[3][63:56] = 8'h00;
		nm_hi = '0;
		nm_hi[0] = 64'h80;
		nm_void_junk = '1;
		nm_void_junk[0][7:0] = 8'h00;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ignored items, empty scans, strength rules, name edge cases
		push_item(1'b0, '1, 8'h7f, 1'b0);          // neither record nor end: no result
		push_item(1'b0, '0, 8'h00, 1'b1);          // bare end on an empty table
		push_item(1'b1, nm_void_junk, 8'h55, 1'b1); // empty name still ends the scan
		push_item(1'b1, nm_a, 8'h80, 1'b0);         // weakest first
		push_item(1'b1, nm_a_junk, 8'h7f, 1'b0);    // same name after trimming, stronger
		push_item(1'b1, nm_a, 8'h7f, 1'b0);         // equal: keep
		push_item(1'b1, nm_a_junk2, 8'hff, 1'b0);   // weaker: keep
		push_item(1'b1, nm_full, 8'h00, 1'b0);      // 32 bytes, no terminator
		push_item(1'b1, nm_full, 8'h01, 1'b0);
		push_item(1'b1, nm_full, 8'h00, 1'b0);
		push_item(1'b1, nm_term31, 8'h80, 1'b0);    // terminator in the last byte
		push_item(1'b0, nm_term31, 8'h7f, 1'b0);    // record flag low: ignored
		push_item(1'b1, '0, 8'h7f, 1'b0);           // all-zero name: dropped
		push_item(1'b1, nm_hi, 8'h7f, 1'b1);        // new name on the end item itself
		push_item(1'b1, nm_hi, 8'h80, 1'b1);        // single-entry scan
		push_item(1'b0, '0, 8'h00, 1'b1);           // table is clear again

		// random scans; the first one overflows the table
		start = items_sent;
		scan_no = 0;
		while (items_sent - start < RANDOM_ITEMS) begin
			// idling phases: sender light / receiver heavy, swapped, then none
			if (items_sent - start < RANDOM_ITEMS / 3) begin
				send_idle_pct = 19;
				recv_idle_pct = 63;
			end else if (items_sent - start < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 63;
				recv_idle_pct = 19;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			if (scan_no == 0 || $urandom_range(99) < 10) begin
				// overfill: distinct first bytes guarantee distinct names
				n_pool = MAX_ENTRIES + $urandom_range(6, 1);
				for (int i = 0; i < n_pool; i++) begin
					pool_len[i] = $urandom_range(NAME_BYTES, 1);
					pool_name[i] = make_name(pool_len[i]);
					pool_name[i][0][7:0] = 8'(i + 1);
					push_item(1'b1, dress(pool_name[i], pool_len[i]), rand_lvl(), 1'b0);
				end
				// revisit kept and dropped names after the table filled
				for (int i = 0; i < 3; i++) begin
					pick = $urandom_range(n_pool - 1);
					push_item(1'b1, dress(pool_name[pick], pool_len[pick]), rand_lvl(), 1'b0);
				end
				pick = $urandom_range(n_pool - 1);
				push_item(1'($urandom_range(1)), dress(pool_name[pick], pool_len[pick]),
					rand_lvl(), 1'b1);
			end else begin
				// short scan over a small pool so names repeat
				n_pool = $urandom_range(6, 1);
				for (int p = 0; p < n_pool; p++) begin
					pool_len[p] = pick_len();
					pool_name[p] = make_name(pool_len[p]);
				end
				n_items = $urandom_range(10, 1);
				for (int i = 0; i < n_items; i++) begin
					pick = $urandom_range(n_pool - 1);
					last = (i == n_items - 1);
					present = last ? ($urandom_range(3) != 0) : ($urandom_range(99) >= 8);
					push_item(present, dress(pool_name[pick], pool_len[pick]), rand_lvl(), last);
				end
			end
			scan_no++;
		end
		s_tvalid <= 1'b0;

		// drain: pending is registered, so look in the cycle after the last transfer
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
src/dksk_pkg.sv
src/dksk_front.sv
src/dksk_queue.sv
src/dksk_back.sv
src/dedup_keep_strongest_by_key_core.sv
tb/sv/dksk_scan_checker.sv
tb/sv/tb_dedup_keep_strongest_by_key_core.sv
